// ----- rtl/cpg_pkg.sv -----
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared constants for the circle point generator: default coordinate
// width, step queue depth, register indexes and point select codes.
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int CPG_COORD_BITS  = 10;
  localparam int CPG_QUEUE_DEPTH = 2;
  localparam int CPG_CFG_IDX_W   = 2;
  localparam int CPG_SEL_W       = 3;

  // Extra decision bits over the coordinate width.
  localparam int CPG_DEC_EXTRA   = 3;

  // Configuration register indexes.
  localparam logic [CPG_CFG_IDX_W-1:0] CPG_REG_CENTER_X = 2'd0;
  localparam logic [CPG_CFG_IDX_W-1:0] CPG_REG_CENTER_Y = 2'd1;
  localparam logic [CPG_CFG_IDX_W-1:0] CPG_REG_RADIUS   = 2'd2;

  // Point select codes within one step.
  localparam logic [CPG_SEL_W-1:0] CPG_SEL_FIRST = 3'd0;
  localparam logic [CPG_SEL_W-1:0] CPG_SEL_LAST  = 3'd7;

endpackage

// ----- rtl/circle_point_generator_unit.sv -----
// ----------------------------------------------------------------------------
// circle_point_generator_unit
// Midpoint circle rasterizer: start items load the walk from the radius
// register, productive advance items each yield the eight mirrored points of a step.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid / in_ready   | in_start_req
//   out     | output    | out_valid / out_ready | point_x, point_y, flags
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Flow: a start item yields nothing. A productive advance item passes
// once through the front end and yields eight points from the emitter,
// one point per cycle while out_ready is high, so the single output port
// sets the step rate. With the queue and emitter idle, the first point is
// valid once its item has passed the queue slot and the output register.
// Reset: rst_n is synchronous, active low; it clears the walk, the queue,
// the emitter and the config registers.
// Stalls: the front end stalls only when the step queue is full; the
// emitter holds its output register while out_ready is low.
//
module circle_point_generator_unit
  import cpg_pkg::*;
#(
  parameter int COORD_BITS = CPG_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start_req,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   out_point_x,
  output logic signed [COORD_BITS:0]   out_point_y,
  output logic                         out_step_last,
  output logic                         out_circle_done,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CPG_CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  localparam int QW = 2 * COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] center_x_r, center_y_r;
  logic        [COORD_BITS-2:0] radius_r;

  logic                         push_valid, push_ready, push_done;
  logic signed [COORD_BITS-1:0] push_x, push_y;
  logic                         q_valid, q_ready;
  logic        [QW-1:0]         q_data;
  logic signed [COORD_BITS-1:0] q_x, q_y;
  logic                         q_done;

  // Register writes are always taken; extra data bits and unknown
  // indexes drop silently.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CPG_REG_CENTER_X: center_x_r <= cfg_data;
        CPG_REG_CENTER_Y: center_y_r <= cfg_data;
        CPG_REG_RADIUS:   radius_r   <= cfg_data[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  // Front end: classify items and advance the decision walk.
  cpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .radius       (radius_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_x       (push_x),
    .push_y       (push_y),
    .push_done    (push_done)
  );

  // Queue of pending steps; decouples the walk from point output.
  cpg_queue #(
    .WIDTH (QW),
    .DEPTH (CPG_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_done, push_x, push_y}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_done = q_data[QW-1];
  assign q_x    = q_data[2*COORD_BITS-1:COORD_BITS];
  assign q_y    = q_data[COORD_BITS-1:0];

  // Back end: mirror each step into eight points around the live center.
  cpg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .center_x        (center_x_r),
    .center_y        (center_y_r),
    .step_valid      (q_valid),
    .step_ready      (q_ready),
    .step_x          (q_x),
    .step_y          (q_y),
    .step_done       (q_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_step_last   (out_step_last),
    .out_circle_done (out_circle_done)
  );

  // Output register is empty right after reset.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A full queue must have a step to offer the emitter.
  a_full_has_step: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("front stalled while queue is empty");

  // Points of one step follow each other and share the final-step flag.
  a_step_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_step_last |=>
      out_valid && (out_circle_done == $past(out_circle_done)))
    else $error("step broken before its eighth point");

endmodule

// ----- rtl/cpg_front.sv -----
// ----------------------------------------------------------------------------
// cpg_front
// Accepts start and advance items, runs the midpoint decision walk and
// pushes one step record (x, y, final flag) per productive advance.
// ----------------------------------------------------------------------------
module cpg_front
  import cpg_pkg::*;
#(
  parameter int COORD_BITS = CPG_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start_req,
  input  logic        [COORD_BITS-2:0] radius,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic signed [COORD_BITS-1:0] push_x,
  output logic signed [COORD_BITS-1:0] push_y,
  output logic                         push_done
);

  localparam int DW = COORD_BITS + CPG_DEC_EXTRA;

  logic signed [COORD_BITS-1:0] x_r, x_nxt;
  logic signed [COORD_BITS-1:0] y_r, y_nxt;
  logic signed [DW-1:0]         d_r, d_nxt;
  logic                         active_r, active_nxt;

  logic signed [COORD_BITS-1:0] x_inc, y_dec;
  logic signed [DW-1:0]         x_inc_ext, y_dec_ext, diff, d_pos, d_neg;
  logic        [DW-1:0]         r_ext;
  logic                         step_ok, accept, done;

  assign x_inc     = x_r + COORD_BITS'(1);
  assign y_dec     = y_r - COORD_BITS'(1);
  assign x_inc_ext = {{(DW-COORD_BITS){x_inc[COORD_BITS-1]}}, x_inc};
  assign y_dec_ext = {{(DW-COORD_BITS){y_dec[COORD_BITS-1]}}, y_dec};
  assign diff      = x_inc_ext - y_dec_ext;
  assign d_pos     = d_r + (diff <<< 2) + DW'(10);
  assign d_neg     = d_r + (x_inc_ext <<< 2) + DW'(6);
  assign r_ext     = {{(DW-COORD_BITS+1){1'b0}}, radius};

  assign step_ok    = active_r && !(y_r < x_r);
  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && !in_start_req && step_ok;

  // Final step once the updated y drops below the updated x.
  assign done      = (d_r > 0) ? (y_dec < x_inc) : (y_r < x_inc);
  assign push_x    = x_r;
  assign push_y    = y_r;
  assign push_done = done;

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    d_nxt      = d_r;
    active_nxt = active_r;
    if (accept) begin
      if (in_start_req) begin
        x_nxt      = '0;
        y_nxt      = {1'b0, radius};
        d_nxt      = DW'(3) - (r_ext << 1);
        active_nxt = 1'b1;
      end else if (step_ok) begin
        x_nxt = x_inc;
        if (d_r > 0) begin
          y_nxt = y_dec;
          d_nxt = d_pos;
        end else begin
          d_nxt = d_neg;
        end
        active_nxt = !done;
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      d_r      <= d_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ----- rtl/cpg_queue.sv -----
// ----------------------------------------------------------------------------
// cpg_queue
// Short step queue between the walk front end and the point emitter.
// ----------------------------------------------------------------------------
module cpg_queue
  import cpg_pkg::*;
#(
  parameter int WIDTH = 2 * CPG_COORD_BITS + 1,
  parameter int DEPTH = CPG_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/cpg_back.sv -----
// ----------------------------------------------------------------------------
// cpg_back
// Takes one step record and emits its eight mirrored points, one per
// cycle while out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module cpg_back
  import cpg_pkg::*;
#(
  parameter int COORD_BITS = CPG_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic                         step_valid,
  output logic                         step_ready,
  input  logic signed [COORD_BITS-1:0] step_x,
  input  logic signed [COORD_BITS-1:0] step_y,
  input  logic                         step_done,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   out_point_x,
  output logic signed [COORD_BITS:0]   out_point_y,
  output logic                         out_step_last,
  output logic                         out_circle_done
);

  logic [CPG_SEL_W-1:0]       sel_r, sel_nxt;
  logic                       valid_r, valid_nxt;
  logic signed [COORD_BITS:0] px_r, py_r, px, py, a_ext, b_ext;
  logic signed [COORD_BITS:0] cx_ext, cy_ext;
  logic signed [COORD_BITS-1:0] a, b;
  logic                       last_r, done_r, load, is_last;

  // sel[2] swaps x and y, sel[1] mirrors the x offset, sel[0] the y offset.
  assign a      = sel_r[2] ? step_y : step_x;
  assign b      = sel_r[2] ? step_x : step_y;
  assign a_ext  = {a[COORD_BITS-1], a};
  assign b_ext  = {b[COORD_BITS-1], b};
  assign cx_ext = {center_x[COORD_BITS-1], center_x};
  assign cy_ext = {center_y[COORD_BITS-1], center_y};
  assign px     = cx_ext + (sel_r[1] ? -a_ext : a_ext);
  assign py     = cy_ext + (sel_r[0] ? -b_ext : b_ext);

  assign is_last    = (sel_r == CPG_SEL_LAST);
  assign load       = step_valid && (!valid_r || out_ready);
  assign step_ready = load && is_last;

  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      sel_nxt   = is_last ? CPG_SEL_FIRST : sel_r + CPG_SEL_W'(1);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= CPG_SEL_FIRST;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= px;
      py_r   <= py;
      last_r <= is_last;
      done_r <= step_done;
    end
  end

  assign out_valid       = valid_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_step_last   = last_r;
  assign out_circle_done = done_r;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circle_point_generator_unit. A local midpoint-walk
// predictor turns each accepted start/advance item into the points it should
// yield, eight mirrored ones per productive advance; a monitor compares every
// output item with them while sender and receiver both throttle at random.
// ----------------------------------------------------------------------------
module testbench;
  import cpg_pkg::*;

  localparam int CB = CPG_COORD_BITS;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CPG_CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Random items needed before the random test stops.
  localparam int RANDOM_ITEMS = 230;

  // Pause that lets any start or empty advance clear the front end.
  localparam int SETTLE_CYCLES = 12;

  // Run limit in clock cycles.
  localparam int LIMIT_CYCLES = 400_000;

  typedef struct {
    logic signed [CB:0] px;
    logic signed [CB:0] py;
    logic               last;
    logic               done;
  } point_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_HOLD} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_ready;
  logic                     in_start_req;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [CB:0]       out_point_x;
  logic signed [CB:0]       out_point_y;
  logic                     out_step_last;
  logic                     out_circle_done;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CPG_CFG_IDX_W-1:0] cfg_index;
  logic [CB-1:0]            cfg_data;

  circle_point_generator_unit #(
    .COORD_BITS(CB)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_step_last  (out_step_last),
    .out_circle_done(out_circle_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the midpoint walk.
  // --------------------------------------------------------------------------
  int ctr_x   = 0;
  int ctr_y   = 0;
  int rad     = 0;
  int walk_x  = 0;
  int walk_y  = 0;
  int walk_err = 0;
  bit walking = 1'b0;

  point_t pending_points[$];
  bit     mismatch_found = 1'b0;
  int     items_taken    = 0;
  int     burst_left     = 8;

  // Mirror register writes the same way the block should take them.
  function automatic void apply_reg(input logic [CPG_CFG_IDX_W-1:0] idx,
                                    input logic [CB-1:0] data);
    case (idx)
      CPG_REG_CENTER_X: ctr_x = int'($signed(data));
      CPG_REG_CENTER_Y: ctr_y = int'($signed(data));
      CPG_REG_RADIUS:   rad   = int'(data[CB-2:0]);
      default: ;
    endcase
  endfunction

  // Advance the walk for one item; queue the points it yields and return
  // how many there are.
  function automatic int walk_step(input logic start);
    int     px, py, k;
    logic   done;
    point_t pt;
    if (start) begin
      walk_x   = 0;
      walk_y   = rad;
      walk_err = 3 - 2 * rad;
      walking  = 1'b1;
      return 0;
    end
    if (!walking || walk_y < walk_x) begin
      walking = 1'b0;
      return 0;
    end
    px = walk_x;
    py = walk_y;
    walk_x++;
    if (walk_err > 0) begin
      walk_y--;
      walk_err += 4 * (walk_x - walk_y) + 10;
    end else begin
      walk_err += 4 * walk_x + 6;
    end
    done = (walk_y < walk_x);
    if (done) walking = 1'b0;
    // Octant order: (+x,+y) (+x,-y) (-x,+y) (-x,-y), then the same with
    // x and y swapped.
    for (k = 0; k < 8; k++) begin
      if (k < 4) begin
        pt.px = (CB+1)'(ctr_x + ((k < 2) ? px : -px));
        pt.py = (CB+1)'(ctr_y + ((k % 2 == 0) ? py : -py));
      end else begin
        pt.px = (CB+1)'(ctr_x + ((k < 6) ? py : -py));
        pt.py = (CB+1)'(ctr_y + ((k % 2 == 0) ? px : -px));
      end
      pt.last = (k == int'(CPG_SEL_LAST));
      pt.done = done;
      pending_points.push_back(pt);
    end
    return 8;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern whose mode is redrawn at random.
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_left  = 0;
  int       rx_phase = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
      RX_COMB: out_ready <= ((rx_phase % 5) >= 2);
      default: out_ready <= ((rx_phase % 13) >= 6);
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each output item with the oldest predicted point.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_points
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point: expected none, got x=%0d y=%0d last=%0b done=%0b",
                 $time, out_point_x, out_point_y, out_step_last, out_circle_done);
        mismatch_found = 1'b1;
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.px) begin
          $display("%0t: point_x expected %0d, got %0d", $time, want.px, out_point_x);
          mismatch_found = 1'b1;
        end
        if (out_point_y !== want.py) begin
          $display("%0t: point_y expected %0d, got %0d", $time, want.py, out_point_y);
          mismatch_found = 1'b1;
        end
        if (out_step_last !== want.last) begin
          $display("%0t: step_last expected %0b, got %0b", $time, want.last, out_step_last);
          mismatch_found = 1'b1;
        end
        if (out_circle_done !== want.done) begin
          $display("%0t: circle_done expected %0b, got %0b",
                   $time, want.done, out_circle_done);
          mismatch_found = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers.
  // --------------------------------------------------------------------------

  // Send one item; predict at the accepting edge, then maybe open a gap.
  task automatic send_item(input logic start);
    int n;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_start_req <= start;
    do @(posedge clk); while (!in_ready);
    n = walk_step(start);
    if (start || n > 0) items_taken++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      // Mostly short bursts, now and then a long run with no idling.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Drop valid, wait for every predicted point, then let the front end settle.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CPG_CFG_IDX_W-1:0] idx,
                           input logic [CB-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Center value with the extremes weighted up.
  function automatic logic [CB-1:0] pick_center();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(CB-1){1'b0}}};
      1:       return {1'b0, {(CB-1){1'b1}}};
      default: return CB'($urandom_range(0, (1 << CB) - 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Advances with no circle loaded must yield nothing; the spare index
  // must not touch any register.
  task automatic test_idle_advance();
    send_item(1'b0);
    send_item(1'b0);
    wait_for_drain();
    write_reg(REG_UNUSED, {CB{1'b1}});
  endtask

  // Zero radius: one step of eight center points, flagged final. The top
  // data bit of the radius write must be dropped.
  task automatic test_zero_radius();
    write_reg(CPG_REG_CENTER_X, {1'b1, {(CB-1){1'b0}}});
    write_reg(CPG_REG_CENTER_Y, {1'b1, {(CB-1){1'b0}}});
    write_reg(CPG_REG_RADIUS,   {1'b1, {(CB-1){1'b0}}});
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    wait_for_drain();
  endtask

  // Largest radius at both center extremes, a center move mid-circle,
  // then a restart while the walk is still running.
  task automatic test_extremes();
    int i;
    write_reg(CPG_REG_CENTER_X, {1'b0, {(CB-1){1'b1}}});
    write_reg(CPG_REG_CENTER_Y, {1'b0, {(CB-1){1'b1}}});
    write_reg(CPG_REG_RADIUS,   {CB{1'b1}});
    send_item(1'b1);
    for (i = 0; i < 4; i++) send_item(1'b0);
    wait_for_drain();
    write_reg(CPG_REG_CENTER_X, {1'b1, {(CB-1){1'b0}}});
    write_reg(CPG_REG_CENTER_Y, {1'b1, {(CB-1){1'b0}}});
    for (i = 0; i < 3; i++) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    wait_for_drain();
  endtask

  // A full small circle and one advance past its end.
  task automatic test_small_circle();
    write_reg(CPG_REG_CENTER_X, pick_center());
    write_reg(CPG_REG_CENTER_Y, pick_center());
    write_reg(CPG_REG_RADIUS,   CB'(3));
    send_item(1'b1);
    while (walking) send_item(1'b0);
    send_item(1'b0);
    wait_for_drain();
  endtask

  // Mostly complete circles with random setups; the rest are truncated
  // walks, restarts and stray advances.
  task automatic test_random_circles();
    int first, n, cap, mid;
    first = items_taken;
    while (items_taken - first < RANDOM_ITEMS) begin
      wait_for_drain();
      if ($urandom_range(0, 2) != 0) write_reg(CPG_REG_CENTER_X, pick_center());
      if ($urandom_range(0, 2) != 0) write_reg(CPG_REG_CENTER_Y, pick_center());
      if ($urandom_range(0, 3) != 0) begin
        // Keep most circles small; a few reach the widest radii. The
        // dropped top bit is randomized too.
        case ($urandom_range(0, 19))
          0:       n = $urandom_range(61, (1 << (CB-1)) - 1);
          1, 2, 3: n = $urandom_range(13, 60);
          default: n = $urandom_range(0, 12);
        endcase
        write_reg(CPG_REG_RADIUS, {1'($urandom_range(0, 1)), (CB-1)'(n)});
      end
      if ($urandom_range(0, 15) == 0) write_reg(REG_UNUSED, pick_center());

      if ($urandom_range(0, 9) < 7) begin
        send_item(1'b1);
        cap = (rad > 60) ? $urandom_range(5, 40) : 1000;
        mid = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : -1;
        n   = 0;
        while (walking && n < cap) begin
          if (n == mid) begin
            // Move the center while the walk is still going.
            wait_for_drain();
            write_reg(CPG_REG_CENTER_X, pick_center());
            write_reg(CPG_REG_CENTER_Y, pick_center());
          end
          send_item(1'b0);
          n++;
        end
        repeat ($urandom_range(0, 2)) send_item(1'b0);
      end else begin
        repeat ($urandom_range(1, 12)) send_item($urandom_range(0, 3) == 0);
      end
    end
    wait_for_drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_start_req = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CPG_REG_CENTER_X;
    cfg_data     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_advance();
    test_zero_radius();
    test_extremes();
    test_small_circle();
    test_random_circles();

    if (pending_points.size() != 0)
      $display("%0t: %0d predicted points never arrived", $time, pending_points.size());
    if (!mismatch_found && pending_points.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("%0t: timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
